[hdl/imu_time_sync_interpolator_core_defines.svh]
// Assertion macros used by the checker file.
`ifndef IMU_TIME_SYNC_INTERPOLATOR_CORE_DEFINES_SVH
`define IMU_TIME_SYNC_INTERPOLATOR_CORE_DEFINES_SVH

// Same-cycle implication under active-low reset.
`define ASSERT_IMPLY(label, clk, rst_n, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);

// Next-cycle implication under active-low reset.
`define ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);

`endif

[hdl/imu_ts_pkg.sv]
// ----------------------------------------------------------------------------
// IMU time sync package
// Shared widths, sample entry type, ring request type and slot arithmetic.
// ----------------------------------------------------------------------------
package imu_ts_pkg;

  localparam int RING_DEPTH = 16;
  localparam int SLOT_W     = $clog2(RING_DEPTH);
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);
  localparam int TIME_W     = 63;
  localparam int VAL_W      = 16;
  localparam int GAP_W      = 30;
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;
  localparam logic [GAP_W-1:0] GAP_RESET = GAP_W'(200000000);
  localparam logic REG_GAP_LIMIT = 1'b0;

  typedef struct packed {
    logic [TIME_W-1:0]           time_ns;
    logic [2:0][VAL_W-1:0]       acc;
    logic [2:0][VAL_W-1:0]       rate;
    logic [3:0][VAL_W-1:0]       quat;
  } entry_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [SLOT_W-1:0] waddr;
    logic [SLOT_W-1:0] raddr;
  } ring_req_t;

  function automatic logic [SLOT_W-1:0] slot_add(logic [SLOT_W-1:0] slot,
                                                 logic [CNT_W-1:0] k);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(slot) + (CNT_W+1)'(k);
    if (sum >= (CNT_W+1)'(RING_DEPTH)) sum = sum - (CNT_W+1)'(RING_DEPTH);
    return sum[SLOT_W-1:0];
  endfunction

endpackage

[hdl/imu_ts_ring.sv]
// ----------------------------------------------------------------------------
// IMU time sync sample ring
// Sample store with one write port and one registered read port.
// ----------------------------------------------------------------------------
module imu_ts_ring import imu_ts_pkg::*; (
  input  logic      clk_i,
  input  ring_req_t req_i,
  input  entry_t    wdata_i,
  output entry_t    rdata_o
);

  entry_t mem_q [RING_DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= wdata_i;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/imu_time_sync_interpolator_core.sv]
// ----------------------------------------------------------------------------
// IMU time sync interpolator core
// Sample ring with timestamp alignment, linear interpolation and quaternion
// renormalization on one shared iterative datapath.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid_i / in_stall_o) carries push and sync requests.
// A push (func 0) stores one sample and gives no result; the
// oldest sample is overwritten when the ring holds sixteen.
// A sync (func 1) gives exactly one result on the output channel
// (out_valid_o / out_stall_i). It reads and tests the oldest pair, skips
// each sample that lies before the sync time and may drop a sample on a gap.
// Then come the 16-step weight divider, the ten lerp multiplies, the squares,
// the square root, the four normalizing divides and the load of the result.
// A failed sync answers with status 0 and all fields zero.
// While a sync runs, in_stall_o is high. A result waits in the output
// register while out_stall_i is high; pushes are still taken meanwhile, and a
// further sync holds in its last step until the register is free.
// Reset empties the ring and loads gap_limit_ns with 200000000.
// gap_limit_ns is written through the APB port at address 0.
// ----------------------------------------------------------------------------
module imu_time_sync_interpolator_core import imu_ts_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [DATA_W-1:0]        pwdata,
  output logic [DATA_W-1:0]        prdata,
  output logic                     pready,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     func_i,
  input  logic [TIME_W-1:0]        time_ns_i,
  input  logic signed [VAL_W-1:0]  acc_x_i,
  input  logic signed [VAL_W-1:0]  acc_y_i,
  input  logic signed [VAL_W-1:0]  acc_z_i,
  input  logic signed [VAL_W-1:0]  rate_x_i,
  input  logic signed [VAL_W-1:0]  rate_y_i,
  input  logic signed [VAL_W-1:0]  rate_z_i,
  input  logic signed [VAL_W-1:0]  quat_x_i,
  input  logic signed [VAL_W-1:0]  quat_y_i,
  input  logic signed [VAL_W-1:0]  quat_z_i,
  input  logic signed [VAL_W-1:0]  quat_w_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     status_o,
  output logic [TIME_W-1:0]        out_time_ns_o,
  output logic signed [VAL_W-1:0]  out_acc_x_o,
  output logic signed [VAL_W-1:0]  out_acc_y_o,
  output logic signed [VAL_W-1:0]  out_acc_z_o,
  output logic signed [VAL_W-1:0]  out_rate_x_o,
  output logic signed [VAL_W-1:0]  out_rate_y_o,
  output logic signed [VAL_W-1:0]  out_rate_z_o,
  output logic signed [VAL_W-1:0]  out_quat_x_o,
  output logic signed [VAL_W-1:0]  out_quat_y_o,
  output logic signed [VAL_W-1:0]  out_quat_z_o,
  output logic signed [VAL_W-1:0]  out_quat_w_o
);

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_RD0   = 5'd1;
  localparam logic [4:0] ST_RD1   = 5'd2;
  localparam logic [4:0] ST_CAP1  = 5'd3;
  localparam logic [4:0] ST_CHK_A = 5'd4;
  localparam logic [4:0] ST_CHK_B = 5'd5;
  localparam logic [4:0] ST_CHK_C = 5'd6;
  localparam logic [4:0] ST_CHK_D = 5'd7;
  localparam logic [4:0] ST_WSET  = 5'd8;
  localparam logic [4:0] ST_WSUB  = 5'd9;
  localparam logic [4:0] ST_WCMP  = 5'd10;
  localparam logic [4:0] ST_WDIV  = 5'd11;
  localparam logic [4:0] ST_LERP  = 5'd12;
  localparam logic [4:0] ST_SQ    = 5'd13;
  localparam logic [4:0] ST_SQRT  = 5'd14;
  localparam logic [4:0] ST_NSET  = 5'd15;
  localparam logic [4:0] ST_NDIV  = 5'd16;
  localparam logic [4:0] ST_DONE  = 5'd17;

  localparam int NVAL   = 10;
  localparam int QBASE  = 6;
  localparam int W_W    = 17;
  localparam int SQ_W   = 50;
  localparam int ROOT_W = 25;
  localparam int NUM_W  = 40;
  localparam int SUM_W  = 34;

  logic [4:0]              state_q, state_d;
  logic [SLOT_W-1:0]       oldest_q;
  logic [CNT_W-1:0]        count_q;
  logic [GAP_W-1:0]        gap_q;
  logic [TIME_W-1:0]       tsync_q;
  logic                    final_q;
  logic                    ok_q;
  entry_t                  f_q, b_q;
  logic [TIME_W-1:0]       tc_q, d_q;
  logic [TIME_W:0]         rem_q;
  logic [W_W-1:0]          w_q;
  logic [5:0]              cnt_q;
  logic [1:0]              j_q;
  logic [VAL_W-1:0]        vals_q [NVAL];
  logic [SUM_W-1:0]        sum_q;
  logic [SQ_W-1:0]         x_q, res_q, bit_q;
  logic [NUM_W-1:0]        num_q, quo_q;
  logic [ROOT_W-1:0]       nrem_q;
  logic                    out_valid_q, status_q;
  logic [TIME_W-1:0]       out_time_q;
  logic [VAL_W-1:0]        out_vals_q [NVAL];

  ring_req_t               ring_req;
  entry_t                  wentry, rentry;
  logic                    in_acc, cfg_wr;
  logic [SLOT_W-1:0]       slot_b;
  logic [CNT_W-1:0]        count_dec;

  logic [VAL_W*NVAL-1:0]   f_flat, b_flat;
  logic signed [VAL_W-1:0] lf, lb;
  logic signed [VAL_W:0]   ldiff;
  logic signed [W_W:0]     lw;
  logic signed [34:0]      lprod, lp;
  logic [VAL_W-1:0]        lres;
  logic signed [VAL_W-1:0] sq_in;
  logic signed [31:0]      sq;
  logic [TIME_W:0]         wrem_sh;
  logic [SQ_W-1:0]         rt_sum;
  logic [ROOT_W:0]         nrem_sh;
  logic signed [VAL_W-1:0] nq;
  logic [VAL_W:0]          nmag;
  logic [TIME_W-1:0]       gap_ext;

  assign in_acc    = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == REG_GAP_LIMIT) ? DATA_W'(gap_q) : '0;
  assign slot_b    = slot_add(oldest_q, CNT_W'(1));
  assign count_dec = count_q - CNT_W'(1);
  assign gap_ext   = TIME_W'(gap_q);

  assign wentry.time_ns = time_ns_i;
  assign wentry.acc     = {acc_z_i, acc_y_i, acc_x_i};
  assign wentry.rate    = {rate_z_i, rate_y_i, rate_x_i};
  assign wentry.quat    = {quat_w_i, quat_z_i, quat_y_i, quat_x_i};

  always_comb begin
    ring_req.we    = in_acc && !func_i;
    ring_req.waddr = (count_q >= CNT_W'(RING_DEPTH)) ? oldest_q
                                                     : slot_add(oldest_q, count_q);
    ring_req.re    = (state_q == ST_RD0) || (state_q == ST_RD1);
    ring_req.raddr = (state_q == ST_RD0) ? oldest_q : slot_b;
  end

  imu_ts_ring u_ring (
    .clk_i   (clk_i),
    .req_i   (ring_req),
    .wdata_i (wentry),
    .rdata_o (rentry)
  );

  assign f_flat = {f_q.quat, f_q.rate, f_q.acc};
  assign b_flat = {b_q.quat, b_q.rate, b_q.acc};

  always_comb begin
    lf      = f_flat[cnt_q[3:0]*VAL_W +: VAL_W];
    lb      = b_flat[cnt_q[3:0]*VAL_W +: VAL_W];
    ldiff   = (VAL_W+1)'(lb) - (VAL_W+1)'(lf);
    lw      = $signed({1'b0, w_q});
    lprod   = ldiff * lw;
    lp      = lprod + 35'sd32768;
    lres    = lf + lp[31:16];
    sq_in   = vals_q[QBASE + int'(cnt_q[1:0])];
    sq      = sq_in * sq_in;
    wrem_sh = {rem_q[TIME_W-1:0], 1'b0};
    rt_sum  = res_q + bit_q;
    nrem_sh = {nrem_q, num_q[NUM_W-1]};
    nq      = vals_q[QBASE + int'(j_q)];
    nmag    = nq[VAL_W-1] ? (VAL_W+1)'(-(VAL_W+1)'(nq)) : (VAL_W+1)'(nq);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_acc && func_i) state_d = (count_q < CNT_W'(2)) ? ST_DONE : ST_RD0;
      ST_RD0:   state_d = ST_RD1;
      ST_RD1:   state_d = ST_CAP1;
      ST_CAP1:  state_d = final_q ? ST_WSET : ST_CHK_A;
      ST_CHK_A: state_d = (f_q.time_ns > tsync_q) ? ST_DONE : ST_CHK_B;
      ST_CHK_B: begin
        if (b_q.time_ns < tsync_q) state_d = (count_dec < CNT_W'(2)) ? ST_DONE : ST_RD0;
        else state_d = ST_CHK_C;
      end
      ST_CHK_C: begin
        if (tsync_q - f_q.time_ns > gap_ext) begin
          state_d = (count_dec < CNT_W'(2)) ? ST_DONE : ST_RD0;
        end else begin
          state_d = ST_CHK_D;
        end
      end
      ST_CHK_D: begin
        if (b_q.time_ns - tsync_q > gap_ext) begin
          state_d = (count_dec < CNT_W'(2)) ? ST_DONE : ST_RD0;
        end else begin
          state_d = ST_WSET;
        end
      end
      ST_WSET:  state_d = (b_q.time_ns > f_q.time_ns) ? ST_WSUB : ST_LERP;
      ST_WSUB:  state_d = ST_WCMP;
      ST_WCMP:  state_d = (rem_q[TIME_W-1:0] == d_q) ? ST_LERP : ST_WDIV;
      ST_WDIV:  if (cnt_q == 6'd15) state_d = ST_LERP;
      ST_LERP:  if (cnt_q == 6'(NVAL-1)) state_d = ST_SQ;
      ST_SQ: begin
        if (cnt_q == 6'd3) begin
          state_d = ((sum_q + SUM_W'(unsigned'(sq))) == '0) ? ST_DONE : ST_SQRT;
        end
      end
      ST_SQRT:  if (bit_q[1:0] != 2'b00 || bit_q == '0) state_d = ST_NSET;
      ST_NSET:  state_d = ST_NDIV;
      ST_NDIV:  if (cnt_q == 6'(NUM_W)) state_d = (j_q == 2'd3) ? ST_DONE : ST_NSET;
      ST_DONE:  if (!out_valid_q) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      oldest_q    <= '0;
      count_q     <= '0;
      gap_q       <= GAP_RESET;
      out_valid_q <= 1'b0;
      final_q     <= 1'b0;
      ok_q        <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_wr && paddr[2] == REG_GAP_LIMIT) gap_q <= pwdata[GAP_W-1:0];
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc && !func_i) begin
            if (count_q >= CNT_W'(RING_DEPTH)) oldest_q <= slot_b;
            else count_q <= count_q + CNT_W'(1);
          end
          final_q <= 1'b0;
          ok_q    <= 1'b0;
        end
        ST_CHK_B: begin
          if (b_q.time_ns < tsync_q) begin
            oldest_q <= slot_b;
            count_q  <= count_dec;
          end
        end
        ST_CHK_C: begin
          if (tsync_q - f_q.time_ns > gap_ext) begin
            oldest_q <= slot_b;
            count_q  <= count_dec;
            final_q  <= 1'b1;
          end
        end
        ST_CHK_D: begin
          if (b_q.time_ns - tsync_q > gap_ext) begin
            oldest_q <= slot_b;
            count_q  <= count_dec;
            final_q  <= 1'b1;
          end
        end
        ST_SQ:   if (cnt_q == 6'd3) ok_q <= 1'b1;
        ST_NDIV: if (cnt_q == 6'(NUM_W) && j_q == 2'd3) ok_q <= 1'b1;
        ST_DONE: begin
          if (!out_valid_q) out_valid_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        tsync_q <= time_ns_i;
        w_q     <= '0;
        cnt_q   <= '0;
      end
      ST_RD1:  f_q <= rentry;
      ST_CAP1: b_q <= rentry;
      ST_WSET: begin
        if (tsync_q < f_q.time_ns) tc_q <= f_q.time_ns;
        else if (tsync_q > b_q.time_ns) tc_q <= b_q.time_ns;
        else tc_q <= tsync_q;
        w_q   <= '0;
        cnt_q <= '0;
      end
      ST_WSUB: begin
        d_q   <= b_q.time_ns - f_q.time_ns;
        rem_q <= {1'b0, tc_q - f_q.time_ns};
      end
      ST_WCMP: begin
        if (rem_q[TIME_W-1:0] == d_q) w_q <= W_W'(65536);
        cnt_q <= '0;
      end
      ST_WDIV: begin
        if (wrem_sh >= {1'b0, d_q}) begin
          rem_q <= wrem_sh - {1'b0, d_q};
          w_q   <= {w_q[W_W-2:0], 1'b1};
        end else begin
          rem_q <= wrem_sh;
          w_q   <= {w_q[W_W-2:0], 1'b0};
        end
        cnt_q <= (cnt_q == 6'd15) ? '0 : cnt_q + 6'd1;
      end
      ST_LERP: begin
        vals_q[cnt_q[3:0]] <= lres;
        cnt_q <= (cnt_q == 6'(NVAL-1)) ? '0 : cnt_q + 6'd1;
        sum_q <= '0;
      end
      ST_SQ: begin
        sum_q <= sum_q + SUM_W'(unsigned'(sq));
        if (cnt_q == 6'd3) begin
          x_q   <= SQ_W'(sum_q + SUM_W'(unsigned'(sq))) << 16;
          res_q <= '0;
          bit_q <= SQ_W'(1) << 48;
          if ((sum_q + SUM_W'(unsigned'(sq))) == '0) begin
            for (int i = QBASE; i < NVAL; i++) vals_q[i] <= '0;
          end
        end
        cnt_q <= (cnt_q == 6'd3) ? '0 : cnt_q + 6'd1;
        j_q   <= '0;
      end
      ST_SQRT: begin
        if (x_q >= rt_sum) begin
          x_q   <= x_q - rt_sum;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      ST_NSET: begin
        num_q  <= {nmag, 23'b0} + NUM_W'(res_q[ROOT_W-1:1]);
        nrem_q <= '0;
        quo_q  <= '0;
        cnt_q  <= '0;
      end
      ST_NDIV: begin
        if (cnt_q == 6'(NUM_W)) begin
          if (nq[VAL_W-1]) begin
            vals_q[QBASE + int'(j_q)] <= (quo_q > NUM_W'(32768)) ? 16'h8000
                                                              : 16'(-quo_q[VAL_W:0]);
          end else begin
            vals_q[QBASE + int'(j_q)] <= (quo_q > NUM_W'(32767)) ? 16'h7fff
                                                              : quo_q[VAL_W-1:0];
          end
          j_q <= j_q + 2'd1;
        end else begin
          if (nrem_sh >= (ROOT_W+1)'(res_q[ROOT_W-1:0])) begin
            nrem_q <= ROOT_W'(nrem_sh - (ROOT_W+1)'(res_q[ROOT_W-1:0]));
            quo_q  <= {quo_q[NUM_W-2:0], 1'b1};
          end else begin
            nrem_q <= nrem_sh[ROOT_W-1:0];
            quo_q  <= {quo_q[NUM_W-2:0], 1'b0};
          end
          num_q <= {num_q[NUM_W-2:0], 1'b0};
          cnt_q <= cnt_q + 6'd1;
        end
      end
      ST_DONE: begin
        if (!out_valid_q) begin
          status_q   <= ok_q;
          out_time_q <= ok_q ? tsync_q : '0;
          for (int i = 0; i < NVAL; i++) out_vals_q[i] <= ok_q ? vals_q[i] : '0;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign out_time_ns_o = out_time_q;
  assign out_acc_x_o   = out_vals_q[0];
  assign out_acc_y_o   = out_vals_q[1];
  assign out_acc_z_o   = out_vals_q[2];
  assign out_rate_x_o  = out_vals_q[3];
  assign out_rate_y_o  = out_vals_q[4];
  assign out_rate_z_o  = out_vals_q[5];
  assign out_quat_x_o  = out_vals_q[6];
  assign out_quat_y_o  = out_vals_q[7];
  assign out_quat_z_o  = out_vals_q[8];
  assign out_quat_w_o  = out_vals_q[9];

endmodule

[hdl/imu_ts_checker.sv]
// ----------------------------------------------------------------------------
// IMU time sync checker
// Port-level checks on the output channel and the configuration port.
// ----------------------------------------------------------------------------
`include "imu_time_sync_interpolator_core_defines.svh"

module imu_ts_checker import imu_ts_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     pready,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic                     status_o,
  input logic [TIME_W-1:0]        out_time_ns_o,
  input logic signed [VAL_W-1:0]  out_acc_x_o,
  input logic signed [VAL_W-1:0]  out_quat_w_o
);

  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o, "result dropped while stalled")
  `ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(out_time_ns_o) && $stable(status_o), "stalled result changed")
  `ASSERT_IMPLY(a_fail_zero, clk_i, rst_ni, out_valid_o && !status_o, out_time_ns_o == '0 && out_acc_x_o == '0 && out_quat_w_o == '0, "failed sync with nonzero fields")
  `ASSERT_IMPLY(a_pready, clk_i, rst_ni, 1'b1, pready, "pready low")

endmodule

bind imu_time_sync_interpolator_core imu_ts_checker u_imu_ts_checker (.*);
